FILE: rtl/bbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary border dilation package
// Field widths, register indexes, reset values and the per-item control word
// shared by the position controller and the window datapath.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // Widths of the configuration registers and position counters.
  localparam int COL_W     = 11;
  localparam int ROW_W     = 13;
  localparam int RAD_W     = 3;
  localparam int POS_W     = ROW_W + COL_W;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W   = 8;

  // Largest frame height that a register write can select.
  localparam int MAX_HEIGHT = 4096;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

  // Register values after reset.
  localparam logic [COL_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = 13'd1024;
  localparam logic [RAD_W-1:0] RST_RADIUS       = 3'd1;

  // Decisions made for one item when it is accepted.
  typedef struct packed {
    logic capture;  // the item lies inside the frame and updates the line store
    logic pixel;    // black input pixel, zero for drain items
    logic emit;     // the item releases one output pixel
    logic border;   // that output pixel lies in the forced border
    logic last;     // that output pixel is the last one of the frame
  } bbd_item_t;

endpackage : bbd_pkg
`default_nettype wire

FILE: rtl/binary_border_dilation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary border dilation
// Square-window dilation of a one-bit raster stream with a forced black
// border of the same thickness.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock while tready is high and returns
// its result, if any, through the stage and output registers; the output
// register lets the next item enter while a result waits. Output pixels lag
// the input by radius rows plus radius pixels, and radius*width+radius drain
// items (tuser high) finish a frame, whose last pixel carries tlast. After
// reset the line store is swept clear, with tready low; each configuration
// write holds tready low while the row base and the lag reload.
// ----------------------------------------------------------------------------
module binary_border_dilation import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Input items
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // [0] pixel_black, [7:1] zero
  input  logic                 in_tuser,   // [0] flush
  // Result items
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,  // [0] out_black, [7:1] zero
  output logic                 out_tlast   // frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HB = 2 * MAX_RADIUS;

  logic             in_acc;
  logic             clr_busy;
  logic             cfg_busy;
  logic             win_free;
  bbd_item_t        item;
  logic [AW-1:0]    rd_addr;
  logic [RAD_W-1:0] radius;
  logic [HB-1:0]    rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [HB-1:0]    wr_data;
  logic             out_black;

  assign in_tready = !clr_busy && !cfg_busy && win_free;
  assign in_acc    = in_tvalid && in_tready;

  bbd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_acc    (in_acc),
    .in_pixel  (in_tdata[0]),
    .in_flush  (in_tuser),
    .item      (item),
    .rd_addr   (rd_addr),
    .radius    (radius),
    .busy      (cfg_busy)
  );

  bbd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (HB)
  ) u_line_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  bbd_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .item      (item),
    .addr      (rd_addr),
    .radius    (radius),
    .rd_data   (rd_data),
    .free      (win_free),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_black (out_black),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(TDATA_W-1){1'b0}}, out_black};

endmodule : binary_border_dilation
`default_nettype wire

FILE: rtl/bbd_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line store
// One word of column history per pixel column: a single-port write, a
// registered read, and a clearing sweep over all entries after reset.
// ----------------------------------------------------------------------------
module bbd_line_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  output logic                     clr_busy
);

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] clr_addr_r;
  logic          clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule : bbd_line_mem
`default_nettype wire

FILE: rtl/bbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Position controller
// Holds the configuration, the input and output raster positions and the
// output lag, and decides for each accepted item whether it is captured,
// whether it releases an output pixel, and whether that pixel is forced
// black or ends the frame.
// ----------------------------------------------------------------------------
module bbd_ctrl import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_acc,
  input  logic                         in_pixel,
  input  logic                         in_flush,
  output bbd_item_t                    item,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [RAD_W-1:0]             radius,
  output logic                         busy
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [1:0] SETTLE_CYC = 2'd2;

  function automatic logic [COL_W-1:0] clamp_width(input logic [COL_W-1:0] v);
    logic [COL_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = COL_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      res = COL_W'(MAX_WIDTH);
    end
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = ROW_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      res = ROW_W'(MAX_HEIGHT);
    end
    return res;
  endfunction

  function automatic logic [RAD_W-1:0] clamp_radius(input logic [RAD_W-1:0] v);
    logic [RAD_W-1:0] res;
    res = v;
    if (int'(v) > MAX_RADIUS) begin
      res = RAD_W'(MAX_RADIUS);
    end
    return res;
  endfunction

  logic [COL_W-1:0] w_r;
  logic [ROW_W-1:0] h_r;
  logic [RAD_W-1:0] r_r;
  logic [1:0]       settle_r;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [POS_W-1:0] base_r, base_nxt;
  logic [POS_W-1:0] prod_r;
  logic [POS_W-1:0] lag_r;

  logic [POS_W-1:0] pos;
  logic [COL_W:0]   in_col_inc;
  logic [COL_W:0]   out_col_inc;
  bbd_item_t        item_c;

  // Configuration. Values are clamped to the supported range as they are
  // written; a write starts a short reload of the row base and the lag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= clamp_width(RST_FRAME_WIDTH);
      h_r      <= clamp_height(RST_FRAME_HEIGHT);
      r_r      <= clamp_radius(RST_RADIUS);
      settle_r <= SETTLE_CYC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_r <= clamp_width(cfg_data[COL_W-1:0]);
        REG_FRAME_HEIGHT: h_r <= clamp_height(cfg_data[ROW_W-1:0]);
        REG_RADIUS:       r_r <= clamp_radius(cfg_data[RAD_W-1:0]);
        default: ;
      endcase
      settle_r <= SETTLE_CYC;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // Row base (in_row * width) and lag (radius * width + radius), each
  // behind its own register.
  always_ff @(posedge clk) begin
    prod_r <= {{COL_W{1'b0}}, in_row_r} * {{ROW_W{1'b0}}, w_r};
    lag_r  <= {{(POS_W-RAD_W){1'b0}}, r_r} * {{ROW_W{1'b0}}, w_r}
              + {{(POS_W-RAD_W){1'b0}}, r_r};
  end

  always_comb begin
    pos         = base_r + {{ROW_W{1'b0}}, in_col_r};
    in_col_inc  = {1'b0, in_col_r} + (COL_W+1)'(1);
    out_col_inc = {1'b0, out_col_r} + (COL_W+1)'(1);

    item_c.capture = (in_row_r < h_r) && (in_col_r < w_r);
    item_c.pixel   = in_flush ? 1'b0 : in_pixel;
    item_c.emit    = (pos >= lag_r);
    item_c.border  = (out_col_r < {{(COL_W-RAD_W){1'b0}}, r_r})
                  || ({1'b0, out_col_r} + {{(COL_W+1-RAD_W){1'b0}}, r_r} >= {1'b0, w_r})
                  || (out_row_r < {{(ROW_W-RAD_W){1'b0}}, r_r})
                  || ({1'b0, out_row_r} + {{(ROW_W+1-RAD_W){1'b0}}, r_r} >= {1'b0, h_r});
    item_c.last    = ({1'b0, out_row_r} + (ROW_W+1)'(1) >= {1'b0, h_r})
                  && (out_col_inc >= {1'b0, w_r});

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    base_nxt    = base_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;

    if (in_col_inc >= {1'b0, w_r}) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + 1'b1;
      base_nxt   = base_r + {{ROW_W{1'b0}}, w_r};
    end else begin
      in_col_nxt = in_col_inc[COL_W-1:0];
    end

    if (item_c.emit) begin
      if (item_c.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        base_nxt    = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_inc >= {1'b0, w_r}) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      base_r    <= '0;
    end else if (in_acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      base_r    <= base_nxt;
    end else if (settle_r != '0) begin
      // A new width changes where the current row starts.
      base_r <= prod_r;
    end
  end

  assign item    = item_c;
  assign rd_addr = AW'(in_col_r);
  assign radius  = r_r;
  assign busy    = (settle_r != '0);

  a_no_item_while_settling : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> settle_r == '0)
    else $error("item accepted while the row base was reloading");

  a_frame_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && item_c.emit && item_c.last |=>
      in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0
      && base_r == '0)
    else $error("positions not cleared after the last pixel of a frame");

  a_out_pos_holds : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !item_c.emit |=>
      out_col_r == $past(out_col_r) && out_row_r == $past(out_row_r))
    else $error("output position moved on an item without a result");

endmodule : bbd_ctrl
`default_nettype wire

FILE: rtl/bbd_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window datapath
// Updates the column history of the captured pixel, shifts the per-column
// "any black" bits through the window, forms the dilated pixel and holds it
// in the output register.
// ----------------------------------------------------------------------------
module bbd_window import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_acc,
  input  bbd_item_t                    item,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  logic [RAD_W-1:0]             radius,
  input  logic [2*MAX_RADIUS-1:0]      rd_data,
  output logic                         free,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic [2*MAX_RADIUS-1:0]      wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_black,
  output logic                         out_last
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int HB    = 2 * MAX_RADIUS;
  localparam int WIN_W = HB + 1;

  logic            s1_valid_r;
  bbd_item_t       s1_item_r;
  logic [AW-1:0]   s1_addr_r;
  logic            byp_r;
  logic [HB-1:0]   byp_data_r;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic            out_valid_r;
  logic            out_black_r;
  logic            out_last_r;

  logic             s1_adv;
  logic [HB-1:0]    hist_old;
  logic [WIN_W-1:0] hist_full;
  logic [WIN_W-1:0] mask;
  logic             col_any;
  logic [WIN_W-1:0] win_shift;
  logic             black;

  always_comb begin
    for (int i = 0; i < WIN_W; i++) begin
      mask[i] = (i <= 2 * int'(radius));
    end

    s1_adv = s1_valid_r && (!s1_item_r.emit || !out_valid_r || out_ready);

    // The history word just written for the same column is newer than the
    // one the memory returned.
    hist_old  = byp_r ? byp_data_r : rd_data;
    hist_full = {hist_old, s1_item_r.pixel};
    col_any   = |(hist_full & mask);
    win_shift = s1_item_r.capture ? {win_r[WIN_W-2:0], col_any} : win_r;
    black     = s1_item_r.border || (|(win_shift & mask));

    win_nxt = win_r;
    if (s1_adv) begin
      win_nxt = (s1_item_r.emit && s1_item_r.last) ? '0 : win_shift;
    end
  end

  assign wr_en   = s1_adv && s1_item_r.capture;
  assign wr_addr = s1_addr_r;
  assign wr_data = hist_full[HB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_r       <= 1'b0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        byp_r      <= wr_en && (s1_addr_r == addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      win_r <= win_nxt;
      if (s1_adv && s1_item_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r  <= item;
      s1_addr_r  <= addr;
      byp_data_r <= wr_data;
    end
    if (s1_adv && s1_item_r.emit) begin
      out_black_r <= black;
      out_last_r  <= s1_item_r.last;
    end
  end

  assign free      = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_black = out_black_r;
  assign out_last  = out_last_r;

  a_result_registered : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.emit |=> out_valid_r)
    else $error("result of an advancing item was not registered");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_item_r.emit && out_valid_r && !out_ready |-> !free)
    else $error("stage taken while its result could not be stored");

  a_window_clears : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.emit && s1_item_r.last |=> win_r == '0)
    else $error("window not cleared after the last pixel of a frame");

endmodule : bbd_window
`default_nettype wire

FILE: tb/tb_binary_border_dilation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the binary border dilation block
// Drives one-bit pixel frames of many sizes and radii through the stream
// ports. A behavioral dilation predictor tracks the line store, the window
// and the frame positions, and every output item is checked against the
// oldest predicted pixel. A short directed table comes first, then random
// frames under three idling mixes, each mix closing with one larger frame.
// ----------------------------------------------------------------------------
module tb_binary_border_dilation;
  import bbd_pkg::*;

  localparam int WIDTH_MAX     = 1024;
  localparam int RADIUS_MAX    = 4;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int SMALL_ITEMS   = 80;

  // Index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       val;
    logic                   pix;
    logic                   fl;
    chk_t                   chk;
    logic                   blk;
    logic                   lst;
  } dir_row_t;

  typedef struct packed {
    logic black;
    logic last;
  } dil_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata;   // [0] pixel_black, [7:1] zero
  logic                 in_tuser;   // [0] flush
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;  // [0] out_black, [7:1] zero
  logic                 out_tlast;  // frame_last

  binary_border_dilation #(
    .MAX_WIDTH  (WIDTH_MAX),
    .MAX_RADIUS (RADIUS_MAX)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Predictor state: its own copy of the registers, line store and positions.
  logic [8:0]       line_hist [WIDTH_MAX];
  logic [8:0]       col_any;
  int unsigned      p_in_col, p_in_row, p_out_col, p_out_row;
  logic [COL_W-1:0] r_width;
  logic [ROW_W-1:0] r_height;
  logic [RAD_W-1:0] r_radius;

  dil_px_t  dilated_q [$];
  dir_row_t dir_tab [$];

  int snd_idle, rcv_idle;
  int err_count    = 0;
  int n_items_in   = 0;
  int n_results    = 0;
  int n_writes     = 0;
  int quiet_cycles = 0;
  int mode_items   = 0;

  int big_w [3] = '{20, 12, 1};
  int big_h [3] = '{3, 5, 30};
  int big_r [3] = '{1, 4, 0};

  function automatic int unsigned active_width();
    if (r_width == '0) return 1;
    if (r_width > WIDTH_MAX) return WIDTH_MAX;
    return r_width;
  endfunction

  function automatic int unsigned active_height();
    if (r_height == '0) return 1;
    if (r_height > MAX_HEIGHT) return MAX_HEIGHT;
    return r_height;
  endfunction

  function automatic int unsigned active_radius();
    if (r_radius > RADIUS_MAX) return RADIUS_MAX;
    return r_radius;
  endfunction

  function automatic bit at_frame_start();
    return p_in_col == 0 && p_in_row == 0 && p_out_col == 0 && p_out_row == 0;
  endfunction

  // Advances the predictor by one accepted item; returns 1 when it yields a pixel.
  function automatic bit dilate_pixel(input logic pix, input logic fl, output dil_px_t res);
    int unsigned w, h, r, c, pos, lag;
    logic [8:0]  mask, hist;
    w = active_width();
    h = active_height();
    r = active_radius();
    res = '0;
    mask = 9'((32'd1 << (2 * r + 1)) - 1);
    pos = p_in_row * w + p_in_col;
    lag = r * w + r;
    if (p_in_row < h && p_in_col < w) begin
      c = p_in_col % WIDTH_MAX;
      hist = {line_hist[c][7:0], fl ? 1'b0 : pix};
      line_hist[c] = hist;
      col_any = {col_any[7:0], |(hist & mask)};
    end
    p_in_col++;
    if (p_in_col >= w) begin
      p_in_col = 0;
      p_in_row++;
    end
    if (pos < lag) return 1'b0;
    res.black = (p_out_col < r) || (p_out_col + r >= w) || (p_out_row < r) ||
                (p_out_row + r >= h) || (|(col_any & mask));
    res.last  = (p_out_row + 1 >= h) && (p_out_col + 1 >= w);
    if (res.last) begin
      p_in_col  = 0;
      p_in_row  = 0;
      p_out_col = 0;
      p_out_row = 0;
      col_any   = '0;
    end else begin
      p_out_col++;
      if (p_out_col >= w) begin
        p_out_col = 0;
        p_out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] a_idx,
                                       input logic [CFG_W-1:0] a_val);
    dir_row_t row;
    row = '{kind: ROW_WRITE, idx: a_idx, val: a_val, pix: 1'b0, fl: 1'b0,
            chk: CHK_MODEL, blk: 1'b0, lst: 1'b0};
    return row;
  endfunction

  function automatic dir_row_t pix_row(input logic a_pix, input logic a_fl, input chk_t a_chk,
                                       input logic a_blk, input logic a_lst);
    dir_row_t row;
    row = '{kind: ROW_PIXEL, idx: '0, val: '0, pix: a_pix, fl: a_fl,
            chk: a_chk, blk: a_blk, lst: a_lst};
    return row;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (dilated_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    // Items with no result may still be inside the block.
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRAME_WIDTH:  r_width  = val[COL_W-1:0];
      REG_FRAME_HEIGHT: r_height = val[ROW_W-1:0];
      REG_RADIUS:       r_radius = val[RAD_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic pix, input logic fl, input chk_t chk,
                           input logic gb, input logic gl);
    dil_px_t px;
    bit      has;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W-1){1'b0}}, pix};
    in_tuser  <= fl;
    do @(posedge clk); while (in_tready !== 1'b1);
    has = dilate_pixel(pix, fl, px);
    n_items_in++;
    case (chk)
      CHK_MODEL: if (has) dilated_q.push_back(px);
      CHK_GIVEN: dilated_q.push_back('{black: gb, last: gl});
      default: ;
    endcase
  endtask

  // One frame: register writes, the pixels, then the drain items. A nonzero
  // skew cuts the frame short or runs into the next one.
  task automatic run_frame(input int w, input int h, input int r, input int dens,
                           input int skew);
    int   n_pix, n_all, k;
    logic pix, fl;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    n_pix = active_width() * active_height();
    n_all = n_pix + active_radius() * active_width() + active_radius() + skew;
    for (k = 0; k < n_all; k++) begin
      if (k < n_pix) begin
        pix = ($urandom_range(0, 99) < dens);
        fl  = ($urandom_range(0, 15) == 0);
      end else begin
        pix = $urandom_range(0, 1);
        fl  = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 63) == 0) wait_drained();
      send_item(pix, fl, CHK_MODEL, 1'b0, 1'b0);
      mode_items++;
    end
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= rcv_idle);

  always @(posedge clk) begin
    dil_px_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end else if (out_tvalid && out_tready) begin
        n_results++;
        if (dilated_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no pixel pending", n_results));
        end else begin
          want = dilated_q.pop_front();
          if (out_tdata !== {{(TDATA_W-1){1'b0}}, want.black})
            flag_mismatch($sformatf("result %0d out_black: got %h expected %b",
                                    n_results, out_tdata, want.black));
          if (out_tlast !== want.last)
            flag_mismatch($sformatf("result %0d frame_last: got %b expected %b",
                                    n_results, out_tlast, want.last));
        end
      end
    end
  end

  initial begin
    int i, mode, w, h, r, dens, skew;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    snd_idle  = 27;
    rcv_idle  = 74;
    for (i = 0; i < WIDTH_MAX; i++) line_hist[i] = '0;
    col_any   = '0;
    p_in_col  = 0;
    p_in_row  = 0;
    p_out_col = 0;
    p_out_row = 0;
    r_width   = RST_FRAME_WIDTH;
    r_height  = RST_FRAME_HEIGHT;
    r_radius  = RST_RADIUS;

    // A 1x1 frame with no radius returns each pixel at once, marked last.
    dir_tab.push_back(reg_row(REG_FRAME_WIDTH, 1));
    dir_tab.push_back(reg_row(REG_FRAME_HEIGHT, 1));
    dir_tab.push_back(reg_row(REG_RADIUS, 0));
    dir_tab.push_back(reg_row(REG_SPARE, 13'h1fff));
    dir_tab.push_back(pix_row(1'b1, 1'b0, CHK_GIVEN, 1'b1, 1'b1));
    dir_tab.push_back(pix_row(1'b0, 1'b0, CHK_GIVEN, 1'b0, 1'b1));
    // A flush item inside the frame counts as white.
    dir_tab.push_back(pix_row(1'b1, 1'b1, CHK_GIVEN, 1'b0, 1'b1));
    // Zero width and height behave as one.
    dir_tab.push_back(reg_row(REG_FRAME_WIDTH, 0));
    dir_tab.push_back(reg_row(REG_FRAME_HEIGHT, 0));
    dir_tab.push_back(pix_row(1'b1, 1'b0, CHK_GIVEN, 1'b1, 1'b1));
    // Radius 7 saturates to 4: eight items give nothing, then one border pixel.
    // Pixels past the frame act as drain items.
    dir_tab.push_back(reg_row(REG_RADIUS, 7));
    dir_tab.push_back(pix_row(1'b0, 1'b0, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b0, 1'b1, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b1, 1'b0, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b1, 1'b1, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b0, 1'b0, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b1, 1'b0, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b0, 1'b1, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b1, 1'b1, CHK_NONE, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b0, 1'b0, CHK_GIVEN, 1'b1, 1'b1));
    // Radius change inside a frame, before its first output.
    dir_tab.push_back(reg_row(REG_FRAME_WIDTH, 3));
    dir_tab.push_back(reg_row(REG_FRAME_HEIGHT, 2));
    dir_tab.push_back(reg_row(REG_RADIUS, 1));
    dir_tab.push_back(pix_row(1'b1, 1'b0, CHK_MODEL, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b0, 1'b0, CHK_MODEL, 1'b0, 1'b0));
    dir_tab.push_back(reg_row(REG_RADIUS, 0));
    dir_tab.push_back(pix_row(1'b0, 1'b0, CHK_MODEL, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b1, 1'b0, CHK_MODEL, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b0, 1'b0, CHK_MODEL, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b1, 1'b1, CHK_MODEL, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b0, 1'b1, CHK_MODEL, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(1'b1, 1'b0, CHK_MODEL, 1'b0, 1'b0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[j]) begin
      if (dir_tab[j].kind == ROW_WRITE) write_reg(dir_tab[j].idx, dir_tab[j].val);
      else send_item(dir_tab[j].pix, dir_tab[j].fl, dir_tab[j].chk,
                     dir_tab[j].blk, dir_tab[j].lst);
    end

    for (mode = 0; mode < 3; mode++) begin
      snd_idle = (mode == 0) ? 27 : (mode == 1) ? 74 : 0;
      rcv_idle = (mode == 0) ? 74 : (mode == 1) ? 27 : 0;
      mode_items = 0;
      while (mode_items < SMALL_ITEMS) begin
        w    = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 10);
        h    = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
        r    = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        dens = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 15);
        skew = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
        run_frame(w, h, r, dens, skew);
      end
      // Finish any frame left open so the larger one starts clean.
      while (!at_frame_start()) send_item(1'b0, 1'b1, CHK_MODEL, 1'b0, 1'b0);
      run_frame(big_w[mode], big_h[mode], big_r[mode], 3, 0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (dilated_q.size() != 0)
      flag_mismatch($sformatf("%0d predicted pixels never arrived", dilated_q.size()));
    $display("run: %0d pixel items in, %0d output pixels checked, %0d register writes",
             n_items_in, n_results, n_writes);
    $display("run: frames 1x1 up to 20 wide and 30 tall, zero sizes, radius 0..4 and saturated");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: binary_border_dilation.f
rtl/bbd_pkg.sv
rtl/bbd_line_mem.sv
rtl/bbd_ctrl.sv
rtl/bbd_window.sv
rtl/binary_border_dilation.sv
tb/tb_binary_border_dilation.sv
